[hdl/strd_pkg.sv]
// ----------------------------------------------------------------------------
// strd_pkg: shared types and constants of the tone record decoder
// Holds the framing bytes, header layout, verdict codes, record geometry and
// the item type that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package strd_pkg;

	// Framing and header bytes.
	localparam logic [7:0] SYX_START = 8'hF0;
	localparam logic [7:0] SYX_END   = 8'hF7;
	localparam logic [7:0] MAKER_ID  = 8'h41;
	localparam logic [7:0] CMD_DT1   = 8'h12;

	// Header positions counted after the start byte.
	localparam logic [2:0] HDR_MAKER   = 3'd0;
	localparam logic [2:0] HDR_MODEL   = 3'd2;
	localparam logic [2:0] HDR_CMD     = 3'd3;
	localparam logic [2:0] HDR_ADDR_HI = 3'd4;
	localparam logic [2:0] HDR_ADDR_MD = 3'd5;
	localparam logic [2:0] HDR_ADDR_LO = 3'd6;
	localparam logic [2:0] HDR_DONE    = 3'd7;

	// Record geometry. The record size is a power of two.
	localparam int RECORD_BYTES = 256;
	localparam int SLOT_COUNT   = 64;
	localparam int REC_SHIFT    = $clog2(RECORD_BYTES);
	localparam int OFS_W        = REC_SHIFT;
	localparam int ADDR_W       = 21;
	localparam int AREA_SPAN    = SLOT_COUNT * RECORD_BYTES;
	localparam int SS_W         = 7;
	localparam int IDX_W        = 7;

	// Output field widths.
	localparam int SLOT_W   = 6;
	localparam int BOFS_W   = 8;
	localparam int STATUS_W = 3;
	localparam int COUNT_W  = 7;
	localparam int TDATA_W  = 32;

	// Result kinds.
	localparam logic KIND_DATA    = 1'b0;
	localparam logic KIND_VERDICT = 1'b1;

	// Verdict codes.
	localparam logic [STATUS_W-1:0] ST_OK       = 3'd0;
	localparam logic [STATUS_W-1:0] ST_SHORT    = 3'd1;
	localparam logic [STATUS_W-1:0] ST_BAD_HDR  = 3'd2;
	localparam logic [STATUS_W-1:0] ST_BAD_ADDR = 3'd3;
	localparam logic [STATUS_W-1:0] ST_BAD_SUM  = 3'd4;

	// Configuration registers.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_AREA_BASE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MODEL_ID  = 2'd1;
	localparam logic [ADDR_W-1:0] AREA_BASE_RST = 21'h020000;
	localparam logic [6:0]        MODEL_ID_RST  = 7'h16;

	// Queue between front and back end.
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [1:0] {
		EV_START,
		EV_END,
		EV_HDR,
		EV_BODY
	} ev_kind_t;

	// One classified stream byte.
	typedef struct packed {
		ev_kind_t   kind;
		logic [2:0] pos;
		logic [7:0] data;
	} ev_t;

	typedef struct packed {
		logic [ADDR_W-1:0] area_base;
		logic [6:0]        model_id;
	} cfg_t;

endpackage

[hdl/sysex_tone_record_decoder_core.sv]
// ----------------------------------------------------------------------------
// sysex_tone_record_decoder_core: tone record dump decoder
// Frames system-exclusive data-set messages from a raw byte stream and emits
// tentative record bytes and an end-of-message verdict.
// ----------------------------------------------------------------------------
// Usage:
//   Raw stream bytes enter on the s_ channel, one per accepted item. Results
//   leave on the m_ channel: m_tuser low marks a tentative data byte with its
//   slot and offset, m_tuser high marks the verdict with status and the number
//   of whole records to commit. Each data byte comes out when the next body
//   byte arrives, since the byte before the end byte is the checksum.
//   A byte that causes a result reaches m_tvalid through the queue and the
//   output register: the front end classifies it into the queue when it is
//   accepted, and the back end decodes it into the output register on a pop.
//   The block takes one byte per cycle while the queue has room; a two-item
//   queue between the framing front end and the decoding back end absorbs a
//   stall on either side. When m_tready is low, the output register holds
//   its result, the back end stops, the queue fills and s_tready drops once
//   the queue holds two message bytes. Reset clears the framing state, the
//   queue and the output register and loads the configuration defaults; no
//   clearing pass is needed. The configuration port is always ready; the
//   user must write it only while idle, and the block does not check this.
// ----------------------------------------------------------------------------
module sysex_tone_record_decoder_core
	import strd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [7:0]           s_tdata,    // byte_in[7:0]
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// slot[5:0], byte_offset[13:6], data_byte[21:14], status[24:22],
	// record_count[31:25]
	output logic [TDATA_W-1:0]   m_tdata,
	output logic                 m_tuser,    // result_kind[0]
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [ADDR_W-1:0]    cfg_data
);

	cfg_t cfg_q;
	logic q_full;
	logic push;
	ev_t  push_ev;
	logic pop;
	logic q_nonempty;
	ev_t  head;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.area_base <= AREA_BASE_RST;
			cfg_q.model_id  <= MODEL_ID_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_AREA_BASE: cfg_q.area_base <= cfg_data;
				CFG_MODEL_ID:  cfg_q.model_id  <= cfg_data[6:0];
				default: begin
				end
			endcase
		end
	end

	strd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.q_full   (q_full),
		.push     (push),
		.push_ev  (push_ev)
	);

	strd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_ev  (push_ev),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.head     (head)
	);

	strd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.ev         (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser)
	);

endmodule

[hdl/strd_front.sv]
// ----------------------------------------------------------------------------
// strd_front: message framing front end
// Tracks whether the stream is inside a message and how far the header has
// come, and turns each relevant byte into a classified item for the back end.
// ----------------------------------------------------------------------------
module strd_front
	import strd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,    // byte_in[7:0]
	input  logic       q_full,
	output logic       push,
	output ev_t        push_ev
);

	logic       in_msg_q;
	logic [2:0] hdr_pos_q;
	logic       accept;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	// Classify the byte against the current framing state.
	always_comb begin
		push         = 1'b0;
		push_ev.kind = EV_BODY;
		push_ev.pos  = hdr_pos_q;
		push_ev.data = s_tdata;
		if (accept) begin
			if (!in_msg_q) begin
				if (s_tdata == SYX_START) begin
					push         = 1'b1;
					push_ev.kind = EV_START;
				end
			end else if (s_tdata == SYX_END) begin
				push         = 1'b1;
				push_ev.kind = EV_END;
			end else if (hdr_pos_q != HDR_DONE) begin
				push         = 1'b1;
				push_ev.kind = EV_HDR;
			end else begin
				push         = 1'b1;
				push_ev.kind = EV_BODY;
			end
		end
	end

	// Framing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_msg_q  <= 1'b0;
			hdr_pos_q <= '0;
		end else if (accept) begin
			if (!in_msg_q) begin
				if (s_tdata == SYX_START) begin
					in_msg_q  <= 1'b1;
					hdr_pos_q <= '0;
				end
			end else if (s_tdata == SYX_END) begin
				in_msg_q <= 1'b0;
			end else if (hdr_pos_q != HDR_DONE) begin
				hdr_pos_q <= hdr_pos_q + 3'd1;
			end
		end
	end

endmodule

[hdl/strd_queue.sv]
// ----------------------------------------------------------------------------
// strd_queue: two-entry item queue
// Decouples the front end from the back end so that a stall on one side
// does not at once hold up the other.
// ----------------------------------------------------------------------------
module strd_queue
	import strd_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  ev_t  push_ev,
	output logic full,
	input  logic pop,
	output logic nonempty,
	output ev_t  head
);

	ev_t               mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full     = (cnt_q == QCNT_W'(QDEPTH));
	assign nonempty = (cnt_q != '0);
	assign head     = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_ev;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full && !pop))
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("queue read while empty");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QDEPTH))
		else $error("queue count out of range");

endmodule

[hdl/strd_back.sv]
// ----------------------------------------------------------------------------
// strd_back: message decoding back end
// Checks the header, packs the address, keeps the running checksum, emits
// each data byte one byte late and builds the verdict at the end byte.
// ----------------------------------------------------------------------------
module strd_back
	import strd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  cfg_t               cfg,
	input  logic               q_nonempty,
	input  ev_t                ev,
	output logic               pop,
	output logic               m_tvalid,
	input  logic               m_tready,
	output logic [TDATA_W-1:0] m_tdata,
	output logic               m_tuser
);

	logic              header_bad_q;
	logic [ADDR_W-1:0] addr_q;
	logic [SS_W-1:0]   start_slot_q;
	logic [6:0]        sum_q;
	logic [7:0]        held_q;
	logic              held_valid_q;
	logic [IDX_W-1:0]  rec_idx_q;
	logic [OFS_W-1:0]  ofs_q;

	logic               out_valid_q;
	logic               out_kind_q;
	logic [TDATA_W-1:0] out_data_q;

	logic [ADDR_W-1:0]   addr_hdr;
	logic [ADDR_W-1:0]   hdr_diff;
	logic [SS_W-1:0]     ss_hdr;
	logic [ADDR_W-1:0]   diff;
	logic                addr_ok;
	logic [SS_W:0]       room;
	logic [COUNT_W-1:0]  count;
	logic [STATUS_W-1:0] status;
	logic                any_data;
	logic                produce;
	logic                res_kind;
	logic [TDATA_W-1:0]  res_data;
	logic                ofs_last;

	assign pop = q_nonempty && (!out_valid_q || m_tready);

	// Address after shifting in a header address byte, and its start slot.
	always_comb begin
		addr_hdr = {addr_q[ADDR_W-8:0], ev.data[6:0]};
		hdr_diff = addr_hdr - cfg.area_base;
		ss_hdr   = (addr_hdr >= cfg.area_base) ? SS_W'(hdr_diff >> REC_SHIFT) : '0;
	end

	// Verdict at the end byte.
	always_comb begin
		diff     = addr_q - cfg.area_base;
		addr_ok  = (addr_q >= cfg.area_base) && (diff[REC_SHIFT-1:0] == '0) &&
			({1'b0, diff} < (ADDR_W + 1)'(AREA_SPAN));
		room     = (SS_W + 1)'(SLOT_COUNT) - {1'b0, start_slot_q};
		count    = ({1'b0, rec_idx_q} < room) ? rec_idx_q : COUNT_W'(room);
		any_data = (rec_idx_q != '0) || (ofs_q != '0);
		if (ev.pos != HDR_DONE || !held_valid_q || !any_data) begin
			status = ST_SHORT;
		end else if (header_bad_q) begin
			status = ST_BAD_HDR;
		end else if (rec_idx_q == '0) begin
			status = ST_SHORT;
		end else if (!addr_ok) begin
			status = ST_BAD_ADDR;
		end else if (held_q[6:0] != (7'd0 - sum_q)) begin
			status = ST_BAD_SUM;
		end else begin
			status = ST_OK;
		end
	end

	// Result for the item at the head of the queue.
	always_comb begin
		ofs_last = (ofs_q == OFS_W'(RECORD_BYTES - 1));
		produce  = 1'b0;
		res_kind = KIND_DATA;
		res_data = '0;
		case (ev.kind)
			EV_END: begin
				produce  = 1'b1;
				res_kind = KIND_VERDICT;
				res_data = {(status == ST_OK) ? count : COUNT_W'(0), status,
					8'd0, BOFS_W'(0), SLOT_W'(0)};
			end
			EV_BODY: begin
				produce  = held_valid_q;
				res_data = {COUNT_W'(0), ST_OK, held_q, BOFS_W'(ofs_q),
					SLOT_W'(start_slot_q + rec_idx_q)};
			end
			default: begin
				produce = 1'b0;
			end
		endcase
	end

	// Message state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			header_bad_q <= 1'b0;
			addr_q       <= '0;
			start_slot_q <= '0;
			sum_q        <= '0;
			held_q       <= '0;
			held_valid_q <= 1'b0;
			rec_idx_q    <= '0;
			ofs_q        <= '0;
		end else if (pop) begin
			case (ev.kind)
				EV_START: begin
					header_bad_q <= 1'b0;
					addr_q       <= '0;
					start_slot_q <= '0;
					sum_q        <= '0;
					held_q       <= '0;
					held_valid_q <= 1'b0;
					rec_idx_q    <= '0;
					ofs_q        <= '0;
				end
				EV_HDR: begin
					case (ev.pos) inside
						HDR_MAKER: begin
							if (ev.data != MAKER_ID) header_bad_q <= 1'b1;
						end
						HDR_MODEL: begin
							if (ev.data != {1'b0, cfg.model_id}) header_bad_q <= 1'b1;
						end
						HDR_CMD: begin
							if (ev.data != CMD_DT1) header_bad_q <= 1'b1;
						end
						HDR_ADDR_HI, HDR_ADDR_MD, HDR_ADDR_LO: begin
							addr_q <= addr_hdr;
							sum_q  <= sum_q + ev.data[6:0];
							if (ev.pos == HDR_ADDR_LO) start_slot_q <= ss_hdr;
						end
						default: begin
						end
					endcase
				end
				EV_BODY: begin
					if (held_valid_q) begin
						sum_q <= sum_q + held_q[6:0];
						if (ofs_last) begin
							ofs_q <= '0;
							if (rec_idx_q != '1) rec_idx_q <= rec_idx_q + IDX_W'(1);
						end else begin
							ofs_q <= ofs_q + OFS_W'(1);
						end
					end
					held_q       <= ev.data;
					held_valid_q <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop) begin
			out_valid_q <= produce;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && produce) begin
			out_kind_q <= res_kind;
			out_data_q <= res_data;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = out_data_q;

	a_count_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_kind_q == KIND_VERDICT && out_data_q[24:22] != ST_OK
		|-> out_data_q[31:25] == '0)
		else $error("records counted in a failed verdict");

	a_body_holds: assert property (@(posedge clk) disable iff (!arst_n)
		pop && ev.kind == EV_BODY |=> held_valid_q)
		else $error("body byte not held");

	a_index_grows: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && ev.kind == EV_START) |=> rec_idx_q >= $past(rec_idx_q))
		else $error("record index went backwards inside a message");

endmodule

[dv/sysex_tone_record_decoder_core_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_tone_record_decoder_core_tb: self-checking bench for the record decoder
// Feeds framed tone dumps, broken messages and stray bytes into the stream
// input, tracks the decoder state alongside the block to work out every
// tentative data byte and verdict, and compares each result as it leaves.
// ----------------------------------------------------------------------------
module sysex_tone_record_decoder_core_tb;
	import strd_pkg::*;

	localparam int STALL_LIMIT = 5000;
	localparam int MAX_REPORTS = 40;

	// Register indexes that the block does not decode.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

	typedef enum {FLAW_NONE, FLAW_MAKER, FLAW_MODEL, FLAW_CMD, FLAW_SUM} dump_flaw_t;
	typedef enum {SINK_OPEN, SINK_COIN, SINK_PERIODIC, SINK_SPARSE} sink_mode_t;

	typedef struct packed {
		logic                kind;
		logic [SLOT_W-1:0]   slot;
		logic [BOFS_W-1:0]   ofs;
		logic [7:0]          data;
		logic [STATUS_W-1:0] status;
		logic [COUNT_W-1:0]  count;
	} tone_result_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [7:0]           s_tdata = 8'h00;    // byte_in[7:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	// slot[5:0], byte_offset[13:6], data_byte[21:14], status[24:22],
	// record_count[31:25]
	logic [TDATA_W-1:0]   m_tdata;
	logic                 m_tuser;            // result_kind[0]
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [ADDR_W-1:0]    cfg_data = '0;

	// Shadow copy of the decoder configuration and message state.
	logic [ADDR_W-1:0] cfg_area = AREA_BASE_RST;
	logic [6:0]        cfg_model = MODEL_ID_RST;
	bit                in_dump = 1'b0;
	int unsigned       hdr_seen = 0;
	bit                hdr_flawed = 1'b0;
	logic [ADDR_W-1:0] dump_addr = '0;
	int unsigned       base_slot = 0;
	logic [6:0]        sum7 = '0;
	logic [7:0]        held_byte_q = '0;
	bit                held_present = 1'b0;
	int unsigned       rec_num = 0;
	int unsigned       rec_pos = 0;

	tone_result_t awaited_results[$];
	int unsigned  fail_count = 0;
	int unsigned  items_fed = 0;
	int unsigned  burst_left = 0;
	int unsigned  hold_request = 0;
	int unsigned  hold_left = 0;
	int unsigned  mode_left = 0;
	int unsigned  phase_ctr = 0;
	int unsigned  quiet_cycles = 0;
	sink_mode_t   sink_mode = SINK_OPEN;

	sysex_tone_record_decoder_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #5 clk = ~clk;

	// Advance the shadow decoder by one stream byte and queue what it emits.
	// Returns whether the byte belonged to a message.
	function automatic bit decode_byte(input logic [7:0] b);
		tone_result_t    r;
		logic [ADDR_W-1:0] addr_gap;
		int unsigned     room;
		int unsigned     cnt;
		if (!in_dump) begin
			if (b != SYX_START)
				return 1'b0;
			in_dump = 1'b1;
			hdr_seen = 0;
			hdr_flawed = 1'b0;
			dump_addr = '0;
			base_slot = 0;
			sum7 = '0;
			held_byte_q = '0;
			held_present = 1'b0;
			rec_num = 0;
			rec_pos = 0;
			return 1'b1;
		end
		r = '0;
		// The end byte closes the message with a verdict.
		if (b == SYX_END) begin
			in_dump = 1'b0;
			r.kind = KIND_VERDICT;
			addr_gap = dump_addr - cfg_area;
			if (hdr_seen < HDR_DONE || !held_present || (rec_num == 0 && rec_pos == 0))
				r.status = ST_SHORT;
			else if (hdr_flawed)
				r.status = ST_BAD_HDR;
			else if (rec_num == 0)
				r.status = ST_SHORT;
			else if (dump_addr < cfg_area || addr_gap % RECORD_BYTES != 0 ||
					addr_gap >= AREA_SPAN)
				r.status = ST_BAD_ADDR;
			else if (held_byte_q[6:0] != 7'(7'd0 - sum7))
				r.status = ST_BAD_SUM;
			else begin
				r.status = ST_OK;
				room = SLOT_COUNT - base_slot;
				cnt = (rec_num < room) ? rec_num : room;
				if (cnt > 127)
					cnt = 127;
				r.count = COUNT_W'(cnt);
			end
			awaited_results.insert(awaited_results.size(), r);
			return 1'b1;
		end
		// Header bytes after the start byte.
		if (hdr_seen < HDR_DONE) begin
			case (3'(hdr_seen))
				HDR_MAKER: if (b != MAKER_ID) hdr_flawed = 1'b1;
				HDR_MODEL: if (b != {1'b0, cfg_model}) hdr_flawed = 1'b1;
				HDR_CMD:   if (b != CMD_DT1) hdr_flawed = 1'b1;
				HDR_ADDR_HI, HDR_ADDR_MD, HDR_ADDR_LO: begin
					dump_addr = {dump_addr[13:0], b[6:0]};
					sum7 = sum7 + b[6:0];
				end
				default: ;
			endcase
			hdr_seen++;
			if (hdr_seen == HDR_DONE)
				base_slot = (dump_addr >= cfg_area) ? (dump_addr - cfg_area) / RECORD_BYTES : 0;
			return 1'b1;
		end
		// Body: the previous byte turns out to be data, not the checksum.
		if (held_present) begin
			r.kind = KIND_DATA;
			r.slot = SLOT_W'(base_slot + rec_num);
			r.ofs = BOFS_W'(rec_pos);
			r.data = held_byte_q;
			awaited_results.insert(awaited_results.size(), r);
			sum7 = sum7 + held_byte_q[6:0];
			rec_pos++;
			if (rec_pos >= RECORD_BYTES) begin
				rec_pos = 0;
				if (rec_num < 127)
					rec_num++;
			end
		end
		held_byte_q = b;
		held_present = 1'b1;
		return 1'b1;
	endfunction

	// Offer one byte on the stream input, with random bursts and gaps.
	task automatic push_byte(input logic [7:0] b);
		int unsigned gap;
		gap = 0;
		if (burst_left == 0) begin
			if ($urandom_range(0, 3) == 0) begin
				burst_left = $urandom_range(100, 300);
			end else begin
				burst_left = $urandom_range(1, 12);
				gap = $urandom_range(1, 6);
			end
		end
		burst_left--;
		@(negedge clk);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		if (decode_byte(b))
			items_fed++;
	endtask

	// Drop the stream valid and wait until the block has nothing left in flight.
	task automatic quiesce();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [ADDR_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			CFG_AREA_BASE: cfg_area = value;
			CFG_MODEL_ID:  cfg_model = value[6:0];
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [7:0] any_but_end();
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255)); while (v == SYX_END);
		return v;
	endfunction

	// A 7-bit value with a random top bit, never the end byte.
	function automatic logic [7:0] tag_top(input logic [6:0] v);
		logic [7:0] t;
		t = {1'($urandom_range(0, 1)), v};
		if (t == SYX_END)
			t = {1'b0, v};
		return t;
	endfunction

	function automatic logic [ADDR_W-1:0] slot_addr(input int unsigned s);
		return cfg_area + ADDR_W'(s * RECORD_BYTES);
	endfunction

	// Start byte and the seven header bytes; sum returns the address checksum part.
	task automatic send_header(input logic [ADDR_W-1:0] addr, input dump_flaw_t flaw,
			output logic [6:0] sum);
		logic [7:0] v;
		push_byte(SYX_START);
		v = MAKER_ID;
		if (flaw == FLAW_MAKER)
			do v = any_but_end(); while (v == MAKER_ID);
		push_byte(v);
		push_byte(any_but_end());
		v = {1'b0, cfg_model};
		if (flaw == FLAW_MODEL)
			do v = any_but_end(); while (v == {1'b0, cfg_model});
		push_byte(v);
		v = CMD_DT1;
		if (flaw == FLAW_CMD)
			do v = any_but_end(); while (v == CMD_DT1);
		push_byte(v);
		push_byte(tag_top(addr[20:14]));
		push_byte(tag_top(addr[13:7]));
		push_byte(tag_top(addr[6:0]));
		sum = addr[20:14] + addr[13:7] + addr[6:0];
	endtask

	// A whole dump message, random body bytes, checksum wrong only under FLAW_SUM.
	task automatic send_dump(input logic [ADDR_W-1:0] addr, input int unsigned n_body,
			input dump_flaw_t flaw);
		logic [6:0] sum;
		logic [6:0] ck;
		logic [7:0] b;
		send_header(addr, flaw, sum);
		repeat (n_body) begin
			b = any_but_end();
			sum = sum + b[6:0];
			push_byte(b);
		end
		ck = 7'd0 - sum;
		if (flaw == FLAW_SUM)
			ck = ck + 7'($urandom_range(1, 127));
		push_byte(tag_top(ck));
		push_byte(SYX_END);
	endtask

	// Bytes outside any message, stray end bytes among them.
	task automatic test_stray_bytes();
		push_byte(SYX_END);
		push_byte(8'h00);
		push_byte(8'hFF);
		push_byte(MAKER_ID);
		push_byte(8'h7F);
		push_byte(8'h80);
		push_byte(SYX_END);
		quiesce();
	endtask

	// Messages that end before a whole record, including a start byte as data.
	task automatic test_short_messages();
		logic [6:0] sum;
		push_byte(SYX_START);
		push_byte(SYX_END);
		push_byte(SYX_START);
		push_byte(MAKER_ID);
		push_byte(8'h10);
		push_byte(SYX_END);
		// A start byte inside a message is an ordinary header byte.
		push_byte(SYX_START);
		push_byte(SYX_START);
		push_byte(SYX_END);
		send_header(slot_addr(0), FLAW_NONE, sum);
		push_byte(SYX_END);
		send_dump(slot_addr(0), 0, FLAW_NONE);
		send_header(slot_addr(1), FLAW_NONE, sum);
		push_byte(SYX_START);
		push_byte(8'hAA);
		push_byte(8'h55);
		push_byte(SYX_END);
		quiesce();
	endtask

	// A whole record under the reset configuration, and each header flaw.
	task automatic test_record_dumps();
		// The byte past the last slot's record wraps around to slot zero.
		send_dump(slot_addr(63), RECORD_BYTES + 1, FLAW_NONE);
		send_dump(slot_addr(3), 4, FLAW_MAKER);
		send_dump(slot_addr(3), 4, FLAW_MODEL);
		send_dump(slot_addr(3), 4, FLAW_CMD);
		quiesce();
	endtask

	// Extreme and odd register values, the unused indexes included.
	task automatic test_register_settings();
		write_reg(CFG_AREA_BASE, '0);
		write_reg(CFG_MODEL_ID, '0);
		send_dump(slot_addr(63), 4, FLAW_NONE);
		send_dump(slot_addr(0), 4, FLAW_MODEL);
		quiesce();
		write_reg(CFG_AREA_BASE, 21'h1FFFFF);
		write_reg(CFG_MODEL_ID, 21'h7F);
		send_dump(21'h1FFFFF, 4, FLAW_NONE);
		quiesce();
		// Bits above the model field are dropped.
		write_reg(CFG_MODEL_ID, {14'h3FFF, 7'h2A});
		write_reg(CFG_SPARE_A, 21'($urandom));
		write_reg(CFG_SPARE_B, 21'($urandom));
		write_reg(CFG_AREA_BASE, 21'($urandom));
		send_dump(slot_addr($urandom_range(0, 63)), 4, FLAW_NONE);
		quiesce();
		write_reg(CFG_AREA_BASE, AREA_BASE_RST);
		write_reg(CFG_MODEL_ID, 21'(MODEL_ID_RST));
	endtask

	// The receiver holds off long enough for the block to stall its input.
	task automatic test_output_stall();
		hold_request = 400;
		send_dump(slot_addr(1), 20, FLAW_NONE);
		quiesce();
	endtask

	// Short dumps with random content, plus broken messages and noise.
	task automatic test_random_traffic();
		int unsigned start_items;
		int unsigned msgs;
		int unsigned r;
		int unsigned k;
		logic [ADDR_W-1:0] addr;
		logic [7:0]  v;
		dump_flaw_t  flaw;
		start_items = items_fed;
		msgs = 0;
		while (items_fed - start_items < 60) begin
			msgs++;
			if (msgs % 4 == 0) begin
				quiesce();
				case ($urandom_range(0, 4))
					0: write_reg(CFG_AREA_BASE, '0);
					1: write_reg(CFG_AREA_BASE, 21'h1FFFFF);
					2: write_reg(CFG_AREA_BASE, AREA_BASE_RST);
					3: write_reg(CFG_AREA_BASE, 21'($urandom));
					default: write_reg(CFG_AREA_BASE, 21'($urandom) & ~21'hFF);
				endcase
				case ($urandom_range(0, 3))
					0: write_reg(CFG_MODEL_ID, '0);
					1: write_reg(CFG_MODEL_ID, 21'h7F);
					2: write_reg(CFG_MODEL_ID, 21'(MODEL_ID_RST));
					default: write_reg(CFG_MODEL_ID, 21'($urandom));
				endcase
			end
			k = $urandom_range(0, 99);
			if (k < 70)
				addr = slot_addr($urandom_range(0, 63));
			else if (k < 80)
				addr = slot_addr($urandom_range(0, 63)) + 21'($urandom_range(1, 255));
			else if (k < 90)
				addr = cfg_area - 21'(RECORD_BYTES * $urandom_range(1, 4));
			else
				addr = 21'($urandom);
			flaw = ($urandom_range(0, 99) < 65) ? FLAW_NONE : dump_flaw_t'($urandom_range(1, 4));
			r = $urandom_range(0, 99);
			if (r < 70) begin
				send_dump(addr, $urandom_range(0, 16), flaw);
			end else if (r < 85) begin
				// Message cut off inside the header.
				push_byte(SYX_START);
				repeat ($urandom_range(0, 6)) push_byte(any_but_end());
				push_byte(SYX_END);
			end else begin
				repeat ($urandom_range(1, 8)) begin
					do v = 8'($urandom_range(0, 255)); while (v == SYX_START);
					push_byte(v);
				end
			end
		end
		quiesce();
	endtask

	// Receiver: a long hold when asked, otherwise a changing stall pattern.
	always @(negedge clk) begin
		phase_ctr++;
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else begin
			if (mode_left == 0) begin
				sink_mode = sink_mode_t'($urandom_range(0, 3));
				mode_left = $urandom_range(50, 300);
			end
			mode_left--;
			case (sink_mode)
				SINK_OPEN:     m_tready <= 1'b1;
				SINK_COIN:     m_tready <= 1'($urandom_range(0, 1));
				SINK_PERIODIC: m_tready <= (phase_ctr % 4) != 3;
				default:       m_tready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			fail_count++;
			if (fail_count <= MAX_REPORTS)
				$error("%s: expected %0d, got %0d", name, want, got);
		end
	endtask

	// Compare each delivered result with the oldest expectation.
	always @(posedge clk) begin : result_check
		tone_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				fail_count++;
				if (fail_count <= MAX_REPORTS)
					$error("result with nothing expected: tuser %0b tdata %h", m_tuser, m_tdata);
			end else begin
				want = awaited_results.pop_front();
				check_field("result_kind", want.kind, m_tuser);
				check_field("slot", want.slot, m_tdata[5:0]);
				check_field("byte_offset", want.ofs, m_tdata[13:6]);
				check_field("data_byte", want.data, m_tdata[21:14]);
				check_field("status", want.status, m_tdata[24:22]);
				check_field("record_count", want.count, m_tdata[31:25]);
			end
		end
	end

	// Watchdog: give up when no handshake completes for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_stray_bytes();
		test_short_messages();
		test_record_dumps();
		test_register_settings();
		test_output_stall();
		test_random_traffic();
		quiesce();
		if (fail_count == 0 && awaited_results.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
